>>> rtl/locked_section_dirty_tracker_macros.svh
// Assertion macros shared by the locked section tracker modules.
`ifndef LOCKED_SECTION_DIRTY_TRACKER_MACROS_SVH
`define LOCKED_SECTION_DIRTY_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked at every rising edge outside reset.
`define LSDT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked at every rising edge, reset included.
`define LSDT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LSDT_ASSERT(label, prop, msg)
`define LSDT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/lsdt_pkg.sv
// Shared constants, codes and controller/datapath interface types.
`default_nettype none

package lsdt_pkg;

  localparam int MAX_SECTIONS = 32;
  localparam int IDX_W        = $clog2(MAX_SECTIONS);
  localparam int CNT_W        = 6;
  localparam int SEC_W        = 8;
  localparam int REQ_W        = 3;
  localparam int KIND_W       = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_RESIZE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_MARK   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BEGIN  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_END    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ALL    = 3'd4;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd3;

  // Commands from the controller; at most one is high in a cycle.
  typedef struct packed {
    logic exec;
    logic trim_dec;
    logic emit_end;
    logic scan_report;
    logic scan_skip;
    logic scan_done;
  } lsdt_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic out_free;
    logic req_trim;
    logic req_all;
    logic trim_more;
    logic scan_at_end;
    logic scan_dirty;
  } lsdt_sts_t;

endpackage

`default_nettype wire

>>> rtl/lsdt_datapath.sv
// Section flag table, tracked length, scan pointer and output word register.
`default_nettype none
`include "locked_section_dirty_tracker_macros.svh"

module lsdt_datapath import lsdt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lsdt_cmd_t          cmd,
  output lsdt_sts_t               sts,
  input  wire logic [REQ_W-1:0]   in_req,
  input  wire logic [SEC_W-1:0]   in_arg,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [KIND_W-1:0]       out_kind,
  output logic [SEC_W-1:0]        out_section,
  output logic                    out_was_dirty,
  output logic                    out_error,
  output logic [CNT_W-1:0]        out_count,
  output logic                    out_last
);

  // A section is released (neither bit), clean (locked only) or dirty (both).
  logic [MAX_SECTIONS-1:0] locked, locked_next;
  logic [MAX_SECTIONS-1:0] dirty, dirty_next;
  logic [CNT_W-1:0]        length, length_next;
  logic [CNT_W-1:0]        ptr;
  logic [SEC_W-1:0]        sec_hold;
  logic                    was_dirty_hold;

  logic [IDX_W-1:0]        arg_idx;
  logic [IDX_W-1:0]        top_idx;
  logic [IDX_W-1:0]        ptr_idx;
  logic [SEC_W-1:0]        len_ext;
  logic                    resize_err;
  logic                    begin_err;
  logic                    end_err;
  logic [MAX_SECTIONS-1:0] len_mask;

  logic                    ld;
  logic [KIND_W-1:0]       ld_kind;
  logic [SEC_W-1:0]        ld_section;
  logic                    ld_was_dirty;
  logic                    ld_error;
  logic [CNT_W-1:0]        ld_count;
  logic                    ld_last;

  // Request decode and bounds checks.
  assign arg_idx    = in_arg[IDX_W-1:0];
  assign len_ext    = SEC_W'(length);
  assign resize_err = in_arg > SEC_W'(MAX_SECTIONS);
  assign begin_err  = in_arg >= SEC_W'(MAX_SECTIONS);
  assign end_err    = in_arg >= len_ext;
  assign top_idx    = IDX_W'(length - CNT_W'(1));
  assign ptr_idx    = ptr[IDX_W-1:0];

  // Status towards the controller.
  always_comb begin
    sts.out_free    = !out_valid || out_ready;
    sts.req_trim    = (in_req == REQ_END) && !end_err;
    sts.req_all     = (in_req == REQ_ALL);
    sts.trim_more   = (length != '0) && !locked[top_idx];
    sts.scan_at_end = ptr >= length;
    sts.scan_dirty  = dirty[ptr_idx];
  end

  // Next state of the flag table and the tracked length.
  always_comb begin
    locked_next = locked;
    dirty_next  = dirty;
    length_next = length;
    if (cmd.exec) begin
      case (in_req)
        REQ_RESIZE: begin
          if (!resize_err && in_arg != '0) begin
            for (int i = 0; i < MAX_SECTIONS; i++) begin
              if (SEC_W'(i) >= in_arg) begin
                locked_next[i] = 1'b0;
                dirty_next[i]  = 1'b0;
              end
            end
            length_next = CNT_W'(in_arg);
          end
        end
        REQ_MARK: begin
          dirty_next = locked;
        end
        REQ_BEGIN: begin
          if (!begin_err) begin
            locked_next[arg_idx] = 1'b1;
            dirty_next[arg_idx]  = 1'b0;
            if (in_arg >= len_ext) begin
              length_next = CNT_W'(in_arg) + CNT_W'(1);
            end
          end
        end
        REQ_END: begin
          if (!end_err) begin
            locked_next[arg_idx] = 1'b0;
            dirty_next[arg_idx]  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.trim_dec) begin
      length_next = length - CNT_W'(1);
    end else if (cmd.scan_done) begin
      locked_next = '0;
      dirty_next  = '0;
      length_next = '0;
    end
  end

  // Result word to be loaded into the output register.
  always_comb begin
    ld           = 1'b0;
    ld_kind      = KIND_ACK;
    ld_section   = '0;
    ld_was_dirty = 1'b0;
    ld_error     = 1'b0;
    ld_count     = length_next;
    ld_last      = 1'b1;
    priority if (cmd.exec) begin
      case (in_req)
        REQ_RESIZE: begin
          ld       = 1'b1;
          ld_error = resize_err;
        end
        REQ_BEGIN: begin
          ld       = 1'b1;
          ld_error = begin_err;
        end
        REQ_END: begin
          // Only the out-of-range answer is given at once; a valid one waits for trimming.
          ld         = end_err;
          ld_kind    = KIND_END;
          ld_section = in_arg;
          ld_error   = 1'b1;
        end
        REQ_ALL: begin
          ld = 1'b0;
        end
        default: begin
          ld = 1'b1;
        end
      endcase
    end else if (cmd.emit_end) begin
      ld           = 1'b1;
      ld_kind      = KIND_END;
      ld_section   = sec_hold;
      ld_was_dirty = was_dirty_hold;
    end else if (cmd.scan_report) begin
      ld         = 1'b1;
      ld_kind    = KIND_REPORT;
      ld_section = SEC_W'(ptr);
      ld_count   = '0;
      ld_last    = 1'b0;
    end else if (cmd.scan_done) begin
      ld       = 1'b1;
      ld_kind  = KIND_DONE;
      ld_count = '0;
    end else begin
      ld = 1'b0;
    end
  end

  // Table state.
  always_ff @(posedge clk) begin
    if (rst) begin
      locked <= '0;
      dirty  <= '0;
      length <= '0;
    end else begin
      locked <= locked_next;
      dirty  <= dirty_next;
      length <= length_next;
    end
  end

  // Scan pointer and the end-lock answer held over trimming.
  always_ff @(posedge clk) begin
    if (cmd.exec && in_req == REQ_ALL) begin
      ptr <= '0;
    end else if (cmd.scan_report || cmd.scan_skip) begin
      ptr <= ptr + CNT_W'(1);
    end
    if (cmd.exec && in_req == REQ_END && !end_err) begin
      sec_hold       <= in_arg;
      was_dirty_hold <= !locked[arg_idx] || dirty[arg_idx];
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_kind      <= ld_kind;
      out_section   <= ld_section;
      out_was_dirty <= ld_was_dirty;
      out_error     <= ld_error;
      out_count     <= ld_count;
      out_last      <= ld_last;
    end
  end

  // Mask of the entries below the tracked length.
  always_comb begin
    for (int i = 0; i < MAX_SECTIONS; i++) begin
      len_mask[i] = CNT_W'(i) < length;
    end
  end

  `LSDT_ASSERT(a_dirty_is_locked, (dirty & ~locked) == '0, "dirty entry is not locked")
  `LSDT_ASSERT(a_tail_released, (locked & ~len_mask) == '0, "locked entry beyond length")
  `LSDT_ASSERT(a_length_bound, length <= CNT_W'(MAX_SECTIONS), "length beyond table size")
  `LSDT_ASSERT(a_load_free, ld |-> sts.out_free, "output word overwritten")

endmodule

`default_nettype wire

>>> rtl/lsdt_ctrl.sv
// Request sequencer: accepts requests, trims after end lock, walks the table for end-all.
`default_nettype none
`include "locked_section_dirty_tracker_macros.svh"

module lsdt_ctrl import lsdt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire lsdt_sts_t sts,
  output lsdt_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TRIM = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0] state, state_next;

  // Next state and command decode.
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == ST_IDLE) && sts.out_free;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.exec = 1'b1;
          if (sts.req_trim) begin
            state_next = ST_TRIM;
          end else if (sts.req_all) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_TRIM: begin
        // Drop one trailing released entry a cycle, then answer.
        if (sts.trim_more) begin
          cmd.trim_dec = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit_end = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // One entry a cycle; a dirty one waits for room in the output register.
        if (!sts.scan_at_end) begin
          if (!sts.scan_dirty) begin
            cmd.scan_skip = 1'b1;
          end else if (sts.out_free) begin
            cmd.scan_report = 1'b1;
          end
        end else if (sts.out_free) begin
          cmd.scan_done = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `LSDT_ASSERT(a_ready_idle, in_ready |-> state == ST_IDLE, "request taken while busy")
  `LSDT_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one command in a cycle")
  `LSDT_ASSERT(a_trim_exit,
    (state == ST_TRIM && !sts.trim_more && sts.out_free) |=> state == ST_IDLE,
    "trim did not finish")

endmodule

`default_nettype wire

>>> rtl/locked_section_dirty_tracker.sv
// Top level: accepts requests from the input stream and registers each result word.
// Resize, mark dirty, begin lock and out-of-range requests each give one word.
// End lock: trims trailing released entries from the length, then gives one word.
// End-all: walks each tracked entry, gives a word per dirty entry, then a closing word.
// Output stalls hold request acceptance and every result word. Reset releases every entry and zeroes the length.
`default_nettype none

module locked_section_dirty_tracker import lsdt_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // section_or_count[7:0]
  input  wire logic [2:0]   s_axis_tuser,   // req_type[2:0]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // section[7:0], was_dirty[8], error[9],
                                            // tracked_count[15:10]
  output logic [1:0]        m_axis_tuser,   // result_kind[1:0]
  output logic              m_axis_tlast    // last
);

  lsdt_cmd_t         cmd;
  lsdt_sts_t         sts;
  logic [SEC_W-1:0]  section;
  logic              was_dirty;
  logic              error;
  logic [CNT_W-1:0]  tracked_count;

  lsdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsdt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_req        (s_axis_tuser),
    .in_arg        (s_axis_tdata),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_kind      (m_axis_tuser),
    .out_section   (section),
    .out_was_dirty (was_dirty),
    .out_error     (error),
    .out_count     (tracked_count),
    .out_last      (m_axis_tlast)
  );

  // Pack the result word.
  assign m_axis_tdata = {tracked_count, error, was_dirty, section};

endmodule

`default_nettype wire
